// ===== sv/evr_pkg.sv =====
// Shared constants, codes and types for the event loop recorder.
// No dependencies; compiled before the interfaces and the top level.
package evr_pkg;

    localparam int DEPTH         = 32;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int TIME_W        = 32;
    localparam int INIT_CHANNELS = 6;
    localparam int INIT_IDX_W    = $clog2(INIT_CHANNELS);

    localparam int ACTION_W  = 3;
    localparam int CHANNEL_W = 3;
    localparam int TYPE_W    = 2;
    localparam int CYCLES_W  = 3;
    localparam int WORD_W    = CHANNEL_W + CYCLES_W + TYPE_W;
    localparam int ENTRY_W   = TIME_W + WORD_W;

    // Action codes carried by an input transfer.
    localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_RECORD     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_START_REC  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_START_LOOP = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP       = 3'd4;

    typedef enum logic [1:0] {
        MODE_STOPPED   = 2'd0,
        MODE_RECORDING = 2'd1,
        MODE_LOOPING   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FETCH,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    // Stored word layout: channel in the top bits, then cycles, then type.
    typedef struct packed {
        logic [CHANNEL_W-1:0] channel;
        logic [CYCLES_W-1:0]  cycles;
        logic [TYPE_W-1:0]    etype;
    } evt_t;

endpackage

// ===== sv/evr_in_if.sv =====
// Input channel of the event loop recorder: valid/ready handshake and the item fields.
// Depends on evr_pkg for the field widths.
interface evr_in_if
    import evr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ACTION_W-1:0]  action;
    logic [TIME_W-1:0]    now;
    logic [CHANNEL_W-1:0] channel;
    logic [TYPE_W-1:0]    event_type;
    logic [CYCLES_W-1:0]  cycles;

    modport source (
        output valid, action, now, channel, event_type, cycles,
        input  ready
    );

    modport sink (
        input  valid, action, now, channel, event_type, cycles,
        output ready
    );
endinterface

// ===== sv/evr_out_if.sv =====
// Result channel of the event loop recorder: valid/ready handshake and the event fields.
// Depends on evr_pkg for the field widths.
interface evr_out_if
    import evr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CHANNEL_W-1:0] out_channel;
    logic [TYPE_W-1:0]    out_type;
    logic [CYCLES_W-1:0]  out_cycles;
    logic                 last;

    modport source (
        output valid, out_channel, out_type, out_cycles, last,
        input  ready
    );

    modport sink (
        input  valid, out_channel, out_type, out_cycles, last,
        output ready
    );
endinterface

// ===== sv/event_loop_recorder.sv =====
// Event loop recorder top level: event store memory, loop timing and playback sequencer.
// Depends on evr_pkg, evr_in_if and evr_out_if.
//
// The block takes one item at a time. Record, start-recording and stop items, undefined
// actions, and ticks that find nothing left to play finish in the cycle of their transfer.
// Start-looping emits the six initial-state events and holds the input until a flush step
// has closed the burst. A tick in looping mode first emits the initial-state events when
// the loop wraps, then steps through the stored entries it examines: each entry is read
// from the event memory in a fetch state before it is compared against the current time in
// a check state; a flush step closes the burst. A tick whose next stored event is not yet
// due therefore still holds the input through the fetch, check and flush of that entry, and
// a wrapping tick may play a full store of 31 events. The sequence stalls whenever the
// result side holds off while a result is waiting. Results wait in an output register, and
// the next item is taken as soon as the last result of the previous one is in that register.
module event_loop_recorder
    import evr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    evr_in_if.sink          items,
    evr_out_if.source       results,
    input  logic            cfg_we,
    input  logic [INIT_CHANNELS-1:0] cfg_wdata
);

    localparam logic [CNT_W-1:0]      CNT_LIMIT     = CNT_W'(DEPTH - 1);
    localparam logic [INIT_IDX_W-1:0] INIT_LAST_IDX = INIT_IDX_W'(INIT_CHANNELS - 1);

    // Event store: offset from loop start in the upper bits, packed word below.
    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic [ADDR_W-1:0]  rd_addr;

    state_t                   state_reg, state_next;
    mode_t                    mode_reg, mode_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [TIME_W-1:0]        start_reg, start_next;
    logic [TIME_W-1:0]        end_reg, end_next;
    logic [INIT_CHANNELS-1:0] levels_reg;
    logic [INIT_IDX_W-1:0]    init_idx_reg, init_idx_next;
    logic                     play_reg, play_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic                     out_valid_reg, out_valid_next;

    logic [ACTION_W-1:0] action_reg;
    logic [TIME_W-1:0]   now_reg;
    evt_t                pend_reg;
    evt_t                out_evt_reg;
    logic                out_last_reg;

    logic              accept;
    logic              tick_live;
    logic              wrap_hit;
    logic              store_ok;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] wrap_end;
    logic [TIME_W-1:0] due_time;
    logic              due;
    logic              can_load;
    logic [CNT_W-1:0]  ptr_inc;
    evt_t              rd_evt;
    evt_t              cand;
    logic              produce;
    logic              step_ok;
    logic              push;
    evt_t              new_word;

    assign accept      = items.valid & items.ready;
    assign items.ready = (state_reg == ST_IDLE);

    assign since_start = items.now - start_reg;
    assign wrap_end    = items.now + since_start;
    assign tick_live   = (mode_reg == MODE_LOOPING) && (count_reg != '0);
    assign wrap_hit    = (items.now >= end_reg);
    assign store_ok    = (count_reg < CNT_LIMIT);

    assign rd_evt   = evt_t'(rdata_reg[WORD_W-1:0]);
    assign due_time = rdata_reg[ENTRY_W-1:WORD_W] + start_reg;
    assign due      = (now_reg >= due_time);
    assign ptr_inc  = ptr_reg + CNT_W'(1);
    assign can_load = !out_valid_reg || results.ready;
    assign rd_addr  = ptr_reg[ADDR_W-1:0];

    assign new_word.channel = items.channel;
    assign new_word.cycles  = items.cycles;
    assign new_word.etype   = items.event_type;

    // Event memory: written by record transfers, read at the play pointer.
    always_ff @(posedge clk)
    begin
        if (accept && (items.action == ACT_RECORD) && store_ok)
        begin
            mem[count_reg[ADDR_W-1:0]] <= {since_start, new_word};
        end
        rdata_reg <= mem[rd_addr];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (items.action == ACT_START_LOOP)
                    begin
                        state_next = ST_INIT;
                    end
                    else if ((items.action == ACT_TICK) && tick_live)
                    begin
                        if (wrap_hit)
                        begin
                            state_next = ST_INIT;
                        end
                        else if (ptr_reg < count_reg)
                        begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                if (step_ok && (init_idx_reg == INIT_LAST_IDX))
                begin
                    state_next = play_reg ? ST_FETCH : ST_FLUSH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!due)
                begin
                    state_next = ST_FLUSH;
                end
                else if (step_ok)
                begin
                    state_next = (ptr_inc < count_reg) ? ST_FETCH : ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg || can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs. A produced event waits in the pending register until the
    // next one is known, so the final event of a burst can be marked as last.
    always_comb
    begin
        cand.channel = rd_evt.channel;
        cand.cycles  = rd_evt.cycles;
        cand.etype   = rd_evt.etype;
        produce      = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cand.channel = CHANNEL_W'(init_idx_reg);
                cand.cycles  = '0;
                cand.etype   = TYPE_W'(levels_reg[init_idx_reg]);
                produce      = 1'b1;
            end
            ST_CHECK:
            begin
                produce = due;
            end
            ST_IDLE, ST_FETCH, ST_FLUSH:
            begin
                produce = 1'b0;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
        step_ok = produce && (!pend_valid_reg || can_load);
        push    = pend_valid_reg && can_load &&
                  (produce || (state_reg == ST_FLUSH));
    end

    // Control register next values.
    always_comb
    begin
        mode_next       = mode_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        init_idx_next   = init_idx_reg;
        play_next       = play_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;

        if (accept)
        begin
            unique case (items.action)
                ACT_RECORD:
                begin
                    if (store_ok)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_START_REC:
                begin
                    mode_next  = MODE_RECORDING;
                    start_next = items.now;
                end
                ACT_START_LOOP:
                begin
                    mode_next     = MODE_LOOPING;
                    end_next      = wrap_end;
                    start_next    = items.now;
                    ptr_next      = '0;
                    init_idx_next = '0;
                    play_next     = 1'b0;
                end
                ACT_TICK:
                begin
                    if (tick_live && wrap_hit)
                    begin
                        end_next      = wrap_end;
                        start_next    = items.now;
                        ptr_next      = '0;
                        init_idx_next = '0;
                        play_next     = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    mode_next  = MODE_STOPPED;
                    count_next = '0;
                    ptr_next   = '0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        if (step_ok && (state_reg == ST_INIT))
        begin
            init_idx_next = init_idx_reg + INIT_IDX_W'(1);
        end
        if (step_ok && (state_reg == ST_CHECK))
        begin
            ptr_next = ptr_inc;
        end

        if (step_ok)
        begin
            pend_valid_next = 1'b1;
        end
        else if (push)
        begin
            pend_valid_next = 1'b0;
        end

        if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_STOPPED;
            count_reg      <= '0;
            ptr_reg        <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
            levels_reg     <= '0;
            init_idx_reg   <= '0;
            play_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
            init_idx_reg   <= init_idx_next;
            play_reg       <= play_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= items.action;
            now_reg    <= items.now;
        end
        if (step_ok)
        begin
            pend_reg <= cand;
        end
        if (push)
        begin
            out_evt_reg  <= pend_reg;
            // The burst ends when the pending event is released from the flush state.
            out_last_reg <= (state_reg == ST_FLUSH) && (action_reg != ACT_RECORD);
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_evt_reg.channel;
    assign results.out_type    = out_evt_reg.etype;
    assign results.out_cycles  = out_evt_reg.cycles;
    assign results.last        = out_last_reg;

endmodule
